@@ rtl/hbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Hashed block cache package
// Types, constants and helpers shared by the hashed block cache modules.
// ----------------------------------------------------------------------------
`default_nettype none
package hbc_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam int BUCKETS_DEF = 13;
	localparam int BUCKET_W = 6;

	typedef enum logic [1:0] {
		OP_GET     = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_UNPIN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_COUNT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HOME,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  device;
		logic [31:0] block_number;
		logic [4:0]  slot;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic [4:0] slot_out;
		logic       hit;
		logic       needs_fill;
		logic [1:0] status;
	} rsp_t;

	// Fields of one entry as they travel around the ring of cells.
	typedef struct packed {
		logic [7:0]          device;
		logic [31:0]         block;
		logic                valid;
		logic [7:0]          refs;
		logic [31:0]         stamp;
		logic [BUCKET_W-1:0] bucket;
	} entry_t;

	// Commands from the controller to every cell.
	typedef struct packed {
		logic                rotate;
	} ring_ctl_t;

endpackage
`default_nettype wire

@@ rtl/hbc_cell.sv @@
// ----------------------------------------------------------------------------
// Hashed block cache cell
// Holds one entry and passes it to its neighbor whenever the ring rotates.
// ----------------------------------------------------------------------------
`default_nettype none
module hbc_cell
	import hbc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ring_ctl_t ctl,
	input  wire entry_t    prev,
	output entry_t         cur
);

	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.rotate) begin
			entry_q <= prev;
		end
	end

	assign cur = entry_q;

endmodule
`default_nettype wire

@@ rtl/hashed_block_cache_lru.sv @@
// ----------------------------------------------------------------------------
// Hashed block cache tag store with LRU replacement
// Top level: a ring of entry cells and the lookup sequencer.
// ----------------------------------------------------------------------------
// The entries sit in a ring of ENTRIES cells that rotates one place per cycle
// while a transaction scans. Every transaction first finds the home bucket,
// then walks the whole ring once, comparing the entry at the head against the
// request and tracking the best victim, and walks it a second time to write
// the chosen entry back. busy is high from the accepting edge until the
// transaction ends, and a new one is accepted only while busy is low. The
// result is shown for one cycle on rsp with done high, after the second turn
// reaches the entry acted on (entry 0 when a get finds nothing free); it
// cannot be held off, and busy stays high until the second turn ends.
`default_nettype none
module hashed_block_cache_lru
	import hbc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int BUCKETS = BUCKETS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1) + 1;
	localparam int RL = $clog2(BUCKETS);
	localparam logic [63:0] RECIP =
		((64'd1 << (32 + RL)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

	state_t    state_q, state_d;
	req_t      req_q;
	logic [31:0]   quo_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] pos_q;
	logic          pass_q;
	logic [BUCKET_W-1:0] home_q;
	logic          found_q, bfound_q;
	logic [IW-1:0] hit_idx_q, best_q;
	logic [BUCKET_W-1:0] bdist_q;
	logic [31:0]   btime_q;
	rsp_t          rsp_q;
	logic          done_q;

	ring_ctl_t ctl;
	entry_t    ring [ENTRIES];
	entry_t    head, head_new;

	assign head = ring[ENTRIES-1];

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			if (g == 0) begin : g_first
				hbc_cell u_cell (
					.clk(clk), .arst_n(arst_n), .ctl(ctl),
					.prev(head_new),
					.cur(ring[g])
				);
			end else begin : g_rest
				hbc_cell u_cell (
					.clk(clk), .arst_n(arst_n), .ctl(ctl),
					.prev(ring[g-1]),
					.cur(ring[g])
				);
			end
		end
	endgenerate

	// The home bucket comes from the quotient by BUCKETS, taken as a product
	// with a rounded-up reciprocal that is exact over all 32-bit blocks.
	logic [64:0] quo_prod;
	assign quo_prod = 65'(req.block_number) * 65'(RECIP[32:0]);

	logic [BUCKET_W-1:0] hb_mod, bkt_gap;
	logic [BUCKET_W:0]   dsum;
	assign hb_mod = (head.bucket >= BUCKET_W'(BUCKETS))
		? BUCKET_W'(head.bucket - BUCKET_W'(BUCKETS)) : head.bucket;
	assign dsum = {1'b0, hb_mod} + (BUCKET_W + 1)'(BUCKETS) - {1'b0, home_q};
	assign bkt_gap = (dsum >= (BUCKET_W + 1)'(BUCKETS))
		? BUCKET_W'(dsum - (BUCKET_W + 1)'(BUCKETS)) : dsum[BUCKET_W-1:0];

	logic tag_eq, better;
	assign tag_eq = (head.bucket == home_q) && (head.device == req_q.device)
		&& (head.block == req_q.block_number);
	assign better = (head.refs == 8'd0) && (!bfound_q || bkt_gap < bdist_q
		|| (bkt_gap == bdist_q && head.stamp < btime_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_HOME;
			S_HOME: state_d = S_SCAN;
			S_SCAN: if (cnt_q == CW'(2 * ENTRIES - 1)) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Write-back on the second pass at the chosen position.
	logic at_tgt;
	logic [IW-1:0] tgt;
	logic          act;
	always_comb begin
		tgt = IW'(req_q.slot);
		act = 1'b0;
		if (op_t'(req_q.op) == OP_GET) begin
			tgt = found_q ? hit_idx_q : best_q;
			act = (found_q && !(head.refs == 8'hff)) || (!found_q && bfound_q);
		end else begin
			act = ({27'd0, req_q.slot} < 32'(ENTRIES))
				&& !((op_t'(req_q.op) == OP_PIN) ? head.refs == 8'hff : head.refs == 8'd0);
		end
	end
	assign at_tgt = pass_q && (pos_q == tgt);

	always_comb begin
		head_new = head;
		if (at_tgt && act) begin
			unique case (op_t'(req_q.op))
				OP_GET: begin
					head_new.refs  = head.refs + 8'd1;
					head_new.stamp = req_q.now;
					head_new.valid = 1'b1;
					if (!found_q) begin
						head_new.refs   = 8'd1;
						head_new.device = req_q.device;
						head_new.block  = req_q.block_number;
						head_new.bucket = home_q;
					end
				end
				OP_PIN:     head_new.refs = head.refs + 8'd1;
				OP_RELEASE: begin
					head_new.refs  = head.refs - 8'd1;
					head_new.stamp = req_q.now;
				end
				OP_UNPIN:   head_new.refs = head.refs - 8'd1;
				default: ;
			endcase
		end
	end

	always_comb begin
		ctl.rotate = (state_q == S_SCAN);
		busy = (state_q != S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == S_SCAN) cnt_q <= cnt_q + CW'(1);
			else cnt_q <= '0;
			if (state_q == S_SCAN && at_tgt) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
			quo_q <= 32'(quo_prod >> (32 + RL));
		end
		if (state_q == S_HOME) begin
			home_q   <= BUCKET_W'(req_q.block_number - quo_q * 32'(BUCKETS));
			found_q  <= 1'b0;
			bfound_q <= 1'b0;
			pos_q    <= '0;
			pass_q   <= 1'b0;
			bdist_q  <= '0;
			btime_q  <= '0;
			best_q   <= '0;
			hit_idx_q <= '0;
		end else if (state_q == S_SCAN) begin
			if (!pass_q && !found_q && tag_eq) begin
				found_q   <= 1'b1;
				hit_idx_q <= pos_q;
			end
			if (!pass_q && better) begin
				bfound_q <= 1'b1;
				best_q   <= pos_q;
				bdist_q  <= bkt_gap;
				btime_q  <= head.stamp;
			end
			// The head moves to index 0 after each rotate, so positions advance.
			if (pos_q == IW'(ENTRIES - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + IW'(1);
			end
			if (cnt_q == CW'(ENTRIES - 1)) pass_q <= 1'b1;
			if (at_tgt) begin
				rsp_q.slot_out   <= req_q.slot;
				rsp_q.hit        <= 1'b0;
				rsp_q.needs_fill <= 1'b0;
				rsp_q.status     <= act ? ST_OK : ST_COUNT;
				if (op_t'(req_q.op) == OP_GET) begin
					if (found_q) begin
						rsp_q.slot_out   <= 5'(tgt);
						rsp_q.hit        <= 1'b1;
						rsp_q.needs_fill <= act && !head.valid;
					end else if (bfound_q) begin
						rsp_q.slot_out   <= 5'(tgt);
						rsp_q.needs_fill <= 1'b1;
					end else begin
						rsp_q.slot_out <= '0;
						rsp_q.status   <= ST_NOFREE;
					end
				end
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	property p_done_single;
		@(posedge clk) disable iff (!arst_n) done |=> !done;
	endproperty
	assert property (p_done_single) else $error("double result strobe");

	property p_idle_no_done;
		@(posedge clk) disable iff (!arst_n) (state_q == S_IDLE) |-> !done_q || $past(state_q == S_SCAN);
	endproperty
	assert property (p_idle_no_done) else $error("result outside a transaction");

	property p_rotate_scan;
		@(posedge clk) disable iff (!arst_n) ctl.rotate |-> busy;
	endproperty
	assert property (p_rotate_scan) else $error("ring rotates while idle");

endmodule
`default_nettype wire
